// ===== src/shec_pkg.sv =====
package shec_pkg;

  // Geometry and number format
  localparam int NUM_DETECTORS = 6;
  localparam int NUM_FACES     = 2;
  localparam int NUM_STRIPS    = 64;
  localparam int FRAC_BITS     = 16;
  localparam int POS_FRAC      = 14;

  localparam int FACE_DEPTH  = NUM_DETECTORS * NUM_FACES;
  localparam int STRIP_DEPTH = FACE_DEPTH * NUM_STRIPS;
  localparam int FIDX_W      = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
  localparam int SIDX_W      = (STRIP_DEPTH > 1) ? $clog2(STRIP_DEPTH) : 1;

  // 4.785 in Q.24, result shift brings it back to FRAC_BITS
  localparam logic [26:0] POS_MM_K = 27'd80278979;
  localparam int POS_SHIFT = 24 + POS_FRAC - FRAC_BITS;

  // Intermediate widths of the energy path
  localparam int CORR_SHIFT = 2 * POS_FRAC;
  localparam int CORR_W     = 64 - CORR_SHIFT;
  localparam int DIFF_W     = CORR_W + 1;
  localparam int NUM_W      = DIFF_W + FRAC_BITS;
  localparam int QUO_W      = 32;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [30:0] GAIN_RESET = 31'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    CMD_HIT        = 2'd0,
    CMD_STRIP_CORR = 2'd1,
    CMD_FACE_CORR  = 2'd2,
    CMD_STRIP_GAIN = 2'd3
  } cmd_e;

  typedef struct packed {
    logic signed [31:0] first;
    logic signed [31:0] second;
  } coef_t;

  typedef struct packed {
    logic  valid;
    coef_t coef;
  } corr_ent_t;

  // Fields that ride along with a hit
  typedef struct packed {
    logic [2:0]  det;
    logic        face;
    logic [5:0]  strip;
    logic [31:0] time_stamp;
    logic [7:0]  mult;
    logic        main_flag;
  } meta_t;

  // One hit as queued for the back end
  typedef struct packed {
    meta_t              meta;
    logic signed [31:0] energy;
    logic signed [15:0] pos;
    logic signed [31:0] lin;
    logic signed [31:0] quad;
    logic signed [31:0] offset;
    logic signed [31:0] slope;
  } hit_t;

  // Sideband carried through the divider
  typedef struct packed {
    meta_t       meta;
    logic [31:0] pmm;
    logic        neg;
    logic        zero;
    logic        dpos;
  } div_side_t;

  // Front to queue push
  typedef struct packed {
    logic push;
    hit_t item;
  } push_t;

endpackage

// ===== src/shec_front.sv =====
module shec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [2:0]           detector_i,
  input  logic                 face_sel_i,
  input  logic [5:0]           strip_index_i,
  input  logic signed [31:0]   raw_energy_i,
  input  logic signed [15:0]   raw_position_i,
  input  logic [31:0]          hit_time_i,
  input  logic [7:0]           multiplicity_i,
  input  logic                 main_flag_i,
  input  logic signed [31:0]   coef_first_i,
  input  logic signed [31:0]   coef_second_i,
  input  logic                 coef_enable_i,
  input  logic                 full_i,
  output shec_pkg::push_t      push_o
);
  import shec_pkg::*;

  corr_ent_t corr_mem [STRIP_DEPTH];
  coef_t     gain_mem [STRIP_DEPTH];
  coef_t     face_mem [FACE_DEPTH];

  corr_ent_t corr_rd_q;
  coef_t     gain_rd_q;
  coef_t     face_rd_q;

  logic              clr_active_q, clr_active_d;
  logic [SIDX_W-1:0] clr_cnt_q, clr_cnt_d;

  logic               fq_vld_q, fq_vld_d;
  meta_t              fq_meta_q;
  logic signed [31:0] fq_energy_q;
  logic signed [15:0] fq_pos_q;

  logic              accept, idx_ok, push;
  logic [SIDX_W-1:0] sidx;
  logic [FIDX_W-1:0] fidx;
  cmd_e              cmd;

  assign cmd = cmd_e'(cmd_i);

  // Table addressing and range check
  assign fidx = FIDX_W'(int'(detector_i) * NUM_FACES + int'(face_sel_i));
  assign sidx = SIDX_W'((int'(detector_i) * NUM_FACES + int'(face_sel_i)) * NUM_STRIPS
                        + int'(strip_index_i));
  assign idx_ok = (int'(detector_i) < NUM_DETECTORS) && (int'(face_sel_i) < NUM_FACES)
                  && (int'(strip_index_i) < NUM_STRIPS);

  // Handshake: hold off during the clear sweep or when the front slot cannot drain
  assign push       = fq_vld_q && !full_i;
  assign in_stall_o = clr_active_q || (fq_vld_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Valid-mark clear sweep after reset
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SIDX_W'(STRIP_DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_comb begin
    fq_vld_d = fq_vld_q;
    if (accept) begin
      fq_vld_d = (cmd == CMD_HIT) && idx_ok;
    end else if (push) begin
      fq_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      fq_vld_q     <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      fq_vld_q     <= fq_vld_d;
    end
  end

  // Strip correction table with valid marks
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      corr_mem[clr_cnt_q] <= '0;
    end else if (accept && idx_ok && cmd == CMD_STRIP_CORR) begin
      corr_mem[sidx] <= {coef_enable_i, coef_first_i, coef_second_i};
    end
    if (accept) begin
      corr_rd_q <= corr_mem[sidx];
    end
  end

  // Strip gain table
  always_ff @(posedge clk_i) begin
    if (accept && idx_ok && cmd == CMD_STRIP_GAIN) begin
      gain_mem[sidx] <= {coef_first_i, coef_second_i};
    end
    if (accept) begin
      gain_rd_q <= gain_mem[sidx];
    end
  end

  // Face fallback table
  always_ff @(posedge clk_i) begin
    if (accept && idx_ok && cmd == CMD_FACE_CORR) begin
      face_mem[fidx] <= {coef_first_i, coef_second_i};
    end
    if (accept) begin
      face_rd_q <= face_mem[fidx];
    end
  end

  // Hit payload of the front slot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fq_meta_q   <= '{det: detector_i, face: face_sel_i, strip: strip_index_i,
                       time_stamp: hit_time_i, mult: multiplicity_i,
                       main_flag: main_flag_i};
      fq_energy_q <= raw_energy_i;
      fq_pos_q    <= raw_position_i;
    end
  end

  // Pick strip or face correction and hand over
  always_comb begin
    push_o.push        = push;
    push_o.item.meta   = fq_meta_q;
    push_o.item.energy = fq_energy_q;
    push_o.item.pos    = fq_pos_q;
    push_o.item.lin    = corr_rd_q.valid ? corr_rd_q.coef.first  : face_rd_q.first;
    push_o.item.quad   = corr_rd_q.valid ? corr_rd_q.coef.second : face_rd_q.second;
    push_o.item.offset = gain_rd_q.first;
    push_o.item.slope  = gain_rd_q.second;
  end

endmodule

// ===== src/shec_queue.sv =====
module shec_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shec_pkg::push_t push_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output shec_pkg::hit_t  item_o
);
  import shec_pkg::*;

  hit_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              wr, rd;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign wr      = push_i.push && !full_o;
  assign rd      = pop_i && !empty_o;
  assign item_o  = mem_q[rp_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wp_d  = wr ? wp_q + 1'b1 : wp_q;
    rp_d  = rd ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= push_i.item;
    end
  end

endmodule

// ===== src/shec_div.sv =====
module shec_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_vld_i,
  input  logic [shec_pkg::NUM_W-1:0]    num_i,
  input  logic [shec_pkg::QUO_W-1:0]    den_i,
  input  shec_pkg::div_side_t           side_i,
  output logic                          out_vld_o,
  output logic [shec_pkg::QUO_W-1:0]    quo_o,
  output logic                          ovf_o,
  output shec_pkg::div_side_t           side_o
);
  import shec_pkg::*;

  // Stage 0 loads, stages 1..QUO_W each resolve one quotient bit
  logic [QUO_W-1:0] r_q [QUO_W+1];
  logic [QUO_W-1:0] n_q [QUO_W+1];
  logic [QUO_W-1:0] q_q [QUO_W+1];
  logic [QUO_W-1:0] d_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  div_side_t        side_q [QUO_W+1];
  logic [QUO_W:0]   vld_q;

  logic [QUO_W:0]   trial [QUO_W];
  logic             ge [QUO_W];
  logic [QUO_W-1:0] r_nx [QUO_W];

  // Trial subtract per stage
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = {r_q[k], n_q[k][QUO_W-1]};
      ge[k]    = trial[k] >= {1'b0, d_q[k]};
      r_nx[k]  = ge[k] ? QUO_W'(trial[k] - {1'b0, d_q[k]}) : QUO_W'(trial[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-1:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= QUO_W'(num_i[NUM_W-1:QUO_W]);
      n_q[0]    <= num_i[QUO_W-1:0];
      q_q[0]    <= '0;
      d_q[0]    <= den_i;
      ovf_q[0]  <= QUO_W'(num_i[NUM_W-1:QUO_W]) >= den_i;
      side_q[0] <= side_i;
      for (int k = 0; k < QUO_W; k++) begin
        r_q[k+1]    <= r_nx[k];
        n_q[k+1]    <= {n_q[k][QUO_W-2:0], 1'b0};
        q_q[k+1]    <= {q_q[k][QUO_W-2:0], ge[k]};
        d_q[k+1]    <= d_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_vld_o = vld_q[QUO_W];
  assign quo_o     = q_q[QUO_W];
  assign ovf_o     = ovf_q[QUO_W];
  assign side_o    = side_q[QUO_W];

endmodule

// ===== src/shec_back.sv =====
module shec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  output logic               pop_o,
  input  shec_pkg::hit_t     item_i,
  input  logic [30:0]        charge_gain_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output shec_pkg::meta_t    out_meta_o,
  output logic signed [31:0] energy_o,
  output logic signed [31:0] charge_o,
  output logic signed [31:0] pmm_o,
  output logic               fault_o
);
  import shec_pkg::*;

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  logic en;
  logic [4:0] vld_q;  // s1..s5
  logic       e_vld_q, m_vld_q, o_vld_q;
  logic       div_vld;

  // s1: first products
  meta_t              s1_meta_q;
  logic signed [31:0] s1_e_q, s1_quad_q, s1_off_q, s1_slope_q, s1_p2_q;
  logic signed [47:0] s1_lp_q;
  logic signed [43:0] s1_pmm_q;
  // s2: quadratic term, position rounding
  meta_t              s2_meta_q;
  logic signed [31:0] s2_e_q, s2_off_q, s2_slope_q, s2_pmm_q;
  logic signed [47:0] s2_lp_q;
  logic signed [63:0] s2_qp_q;
  // s3: corrected energy
  meta_t              s3_meta_q;
  logic signed [31:0] s3_off_q, s3_slope_q, s3_pmm_q;
  logic signed [CORR_W-1:0] s3_corr_q;
  // s4: difference to offset
  meta_t              s4_meta_q;
  logic signed [31:0] s4_slope_q, s4_pmm_q;
  logic signed [DIFF_W-1:0] s4_diff_q;
  // s5: magnitudes for the divider
  div_side_t          s5_side_q;
  logic [NUM_W-1:0]   s5_num_q;
  logic [QUO_W-1:0]   s5_den_q;

  logic signed [63:0] total, total_sh;
  logic signed [63:0] pmm_sum;
  logic [DIFF_W-1:0]  diff_mag;

  logic [QUO_W-1:0]   div_quo;
  logic               div_ovf;
  div_side_t          div_side;
  logic signed [31:0] energy_d;

  // energy and multiply stages
  meta_t              e_meta_q, m_meta_q;
  logic signed [31:0] e_energy_q, e_pmm_q, m_energy_q, m_pmm_q;
  logic               e_fault_q, m_fault_q;
  logic signed [63:0] m_prod_q;
  logic signed [63:0] ch_sum;
  logic signed [47:0] ch_sh;
  logic signed [31:0] charge_d;

  // Whole back pipeline advances unless the output register is held
  assign en    = !o_vld_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      e_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[3:0], !empty_i};
      e_vld_q <= div_vld;
      m_vld_q <= e_vld_q;
      o_vld_q <= m_vld_q;
    end
  end

  // Correction sum and rounding to FRAC_BITS
  always_comb begin
    total    = (64'(s2_e_q) <<< CORR_SHIFT) - (64'(s2_lp_q) <<< POS_FRAC) - s2_qp_q
               + (64'sd1 <<< (CORR_SHIFT - 1));
    total_sh = total >>> CORR_SHIFT;
    pmm_sum  = 64'(s1_pmm_q) + (64'sd1 <<< (POS_SHIFT - 1));
    diff_mag = s4_diff_q[DIFF_W-1] ? DIFF_W'(-s4_diff_q) : DIFF_W'(s4_diff_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q  <= item_i.meta;
      s1_e_q     <= item_i.energy;
      s1_quad_q  <= item_i.quad;
      s1_off_q   <= item_i.offset;
      s1_slope_q <= item_i.slope;
      s1_p2_q    <= 32'(item_i.pos) * 32'(item_i.pos);
      s1_lp_q    <= 48'(item_i.lin) * 48'(item_i.pos);
      s1_pmm_q   <= 44'(item_i.pos) * $signed({17'd0, POS_MM_K});

      s2_meta_q  <= s1_meta_q;
      s2_e_q     <= s1_e_q;
      s2_off_q   <= s1_off_q;
      s2_slope_q <= s1_slope_q;
      s2_lp_q    <= s1_lp_q;
      s2_qp_q    <= 64'(s1_quad_q) * 64'(s1_p2_q);
      s2_pmm_q   <= 32'(pmm_sum >>> POS_SHIFT);

      s3_meta_q  <= s2_meta_q;
      s3_off_q   <= s2_off_q;
      s3_slope_q <= s2_slope_q;
      s3_pmm_q   <= s2_pmm_q;
      s3_corr_q  <= CORR_W'(total_sh);

      s4_meta_q  <= s3_meta_q;
      s4_slope_q <= s3_slope_q;
      s4_pmm_q   <= s3_pmm_q;
      s4_diff_q  <= DIFF_W'(s3_corr_q) - DIFF_W'(s3_off_q);

      s5_side_q  <= '{meta: s4_meta_q, pmm: s4_pmm_q,
                      neg: s4_diff_q[DIFF_W-1] ^ s4_slope_q[31],
                      zero: s4_slope_q == '0, dpos: !s4_diff_q[DIFF_W-1]};
      s5_num_q   <= {diff_mag, {FRAC_BITS{1'b0}}};
      s5_den_q   <= s4_slope_q[31] ? QUO_W'(-s4_slope_q) : QUO_W'(s4_slope_q);
    end
  end

  shec_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (vld_q[4]),
    .num_i     (s5_num_q),
    .den_i     (s5_den_q),
    .side_i    (s5_side_q),
    .out_vld_o (div_vld),
    .quo_o     (div_quo),
    .ovf_o     (div_ovf),
    .side_o    (div_side)
  );

  // Sign, saturation and zero-slope handling of the quotient
  always_comb begin
    if (div_side.zero) begin
      energy_d = div_side.dpos ? SMAX : SMIN;
    end else if (div_ovf) begin
      energy_d = div_side.neg ? SMIN : SMAX;
    end else if (div_side.neg) begin
      energy_d = (div_quo > 32'h8000_0000) ? SMIN : $signed(-div_quo);
    end else begin
      energy_d = div_quo[31] ? SMAX : $signed(div_quo);
    end
  end

  // Charge rounding and saturation
  always_comb begin
    ch_sum = m_prod_q + (64'sd1 <<< (FRAC_BITS - 1));
    ch_sh  = 48'(ch_sum >>> FRAC_BITS);
    if (ch_sh > 48'(SMAX)) begin
      charge_d = SMAX;
    end else if (ch_sh < 48'(SMIN)) begin
      charge_d = SMIN;
    end else begin
      charge_d = 32'(ch_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_meta_q   <= div_side.meta;
      e_energy_q <= energy_d;
      e_pmm_q    <= div_side.pmm;
      e_fault_q  <= div_side.zero;

      m_meta_q   <= e_meta_q;
      m_energy_q <= e_energy_q;
      m_pmm_q    <= e_pmm_q;
      m_fault_q  <= e_fault_q;
      m_prod_q   <= 64'(e_energy_q) * $signed({33'd0, charge_gain_i});

      out_meta_o <= m_meta_q;
      energy_o   <= m_energy_q;
      charge_o   <= charge_d;
      pmm_o      <= m_pmm_q;
      fault_o    <= m_fault_q;
    end
  end

  assign out_valid_o = o_vld_q;

endmodule

// ===== src/strip_hit_energy_calibrator.sv =====
// Strip hit energy calibrator.
// Input channel (in_valid_i / in_stall_o): one item per transfer. cmd 1..3 load
// the strip correction, face fallback and strip gain tables and give no result;
// cmd 0 is a hit and gives one result, unless an index is out of range.
// Output channel (out_valid_o / out_stall_i): one calibrated hit per transfer,
// in input order.
// Config channel (cfg_valid_i / cfg_ready_o): writes charge_gain; always ready,
// write only while no hit is in flight.
// Throughput: one item per cycle while in_stall_o is low. Path of a hit to
// out_valid_o: table read into the front slot at the transfer,
// then queue, five arithmetic stages, a 33-stage divider (load stage plus one
// quotient bit per stage) and three stages of saturation and charge gain.
// Reset: the strip valid marks are cleared by a sweep of one entry per cycle
// over all 768 entries, while in_stall_o is high; charge_gain returns to 1.0.
// When the receiver stalls, the back pipeline holds; the four-entry queue and
// the front slot keep taking items until they fill, then in_stall_o rises.
module strip_hit_energy_calibrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [2:0]         detector_i,
  input  logic               face_sel_i,
  input  logic [5:0]         strip_index_i,
  input  logic signed [31:0] raw_energy_i,
  input  logic signed [15:0] raw_position_i,
  input  logic [31:0]        hit_time_i,
  input  logic [7:0]         multiplicity_i,
  input  logic               main_flag_i,
  input  logic signed [31:0] coef_first_i,
  input  logic signed [31:0] coef_second_i,
  input  logic               coef_enable_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_detector_o,
  output logic               out_face_o,
  output logic [5:0]         out_strip_o,
  output logic signed [31:0] calibrated_energy_o,
  output logic signed [31:0] charge_estimate_o,
  output logic signed [31:0] position_mm_o,
  output logic [31:0]        out_time_o,
  output logic [7:0]         out_multiplicity_o,
  output logic               out_main_flag_o,
  output logic               divide_fault_o
);
  import shec_pkg::*;

  logic [30:0] gain_q;
  push_t       push;
  hit_t        q_item;
  logic        q_full, q_empty, q_pop;
  meta_t       out_meta;

  // Charge gain register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  shec_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .detector_i     (detector_i),
    .face_sel_i     (face_sel_i),
    .strip_index_i  (strip_index_i),
    .raw_energy_i   (raw_energy_i),
    .raw_position_i (raw_position_i),
    .hit_time_i     (hit_time_i),
    .multiplicity_i (multiplicity_i),
    .main_flag_i    (main_flag_i),
    .coef_first_i   (coef_first_i),
    .coef_second_i  (coef_second_i),
    .coef_enable_i  (coef_enable_i),
    .full_i         (q_full),
    .push_o         (push)
  );

  shec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  shec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .item_i        (q_item),
    .charge_gain_i (gain_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_meta_o    (out_meta),
    .energy_o      (calibrated_energy_o),
    .charge_o      (charge_estimate_o),
    .pmm_o         (position_mm_o),
    .fault_o       (divide_fault_o)
  );

  assign out_detector_o     = out_meta.det;
  assign out_face_o         = out_meta.face;
  assign out_strip_o        = out_meta.strip;
  assign out_time_o         = out_meta.time_stamp;
  assign out_multiplicity_o = out_meta.mult;
  assign out_main_flag_o    = out_meta.main_flag;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import shec_pkg::*;

  // One input item as offered on the hit/load channel
  typedef struct {
    cmd_e               cmd;
    logic [2:0]         det;
    logic               face;
    logic [5:0]         strip;
    logic signed [31:0] energy;
    logic signed [15:0] pos;
    logic [31:0]        tstamp;
    logic [7:0]         mult;
    logic               mflag;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic               en;
  } item_t;

  // One calibrated hit
  typedef struct packed {
    logic [2:0]         det;
    logic               face;
    logic [5:0]         strip;
    logic signed [31:0] energy;
    logic signed [31:0] charge;
    logic signed [31:0] pmm;
    logic [31:0]        tstamp;
    logic [7:0]         mult;
    logic               mflag;
    logic               fault;
  } cal_hit_t;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 80;
  // In-range random hits only go to the first strips of each face, whose gains are all loaded
  localparam int LOADED_STRIPS = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = '0;
  logic [2:0]         detector = '0;
  logic               face_sel = 1'b0;
  logic [5:0]         strip_index = '0;
  logic signed [31:0] raw_energy = '0;
  logic signed [15:0] raw_position = '0;
  logic [31:0]        hit_time = '0;
  logic [7:0]         multiplicity = '0;
  logic               main_flag = 1'b0;
  logic signed [31:0] coef_first = '0;
  logic signed [31:0] coef_second = '0;
  logic               coef_enable = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_detector;
  logic               out_face;
  logic [5:0]         out_strip;
  logic signed [31:0] calibrated_energy;
  logic signed [31:0] charge_estimate;
  logic signed [31:0] position_mm;
  logic [31:0]        out_time;
  logic [7:0]         out_multiplicity;
  logic               out_main_flag;
  logic               divide_fault;

  strip_hit_energy_calibrator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cmd_i              (cmd),
    .detector_i         (detector),
    .face_sel_i         (face_sel),
    .strip_index_i      (strip_index),
    .raw_energy_i       (raw_energy),
    .raw_position_i     (raw_position),
    .hit_time_i         (hit_time),
    .multiplicity_i     (multiplicity),
    .main_flag_i        (main_flag),
    .coef_first_i       (coef_first),
    .coef_second_i      (coef_second),
    .coef_enable_i      (coef_enable),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_detector_o     (out_detector),
    .out_face_o         (out_face),
    .out_strip_o        (out_strip),
    .calibrated_energy_o(calibrated_energy),
    .charge_estimate_o  (charge_estimate),
    .position_mm_o      (position_mm),
    .out_time_o         (out_time),
    .out_multiplicity_o (out_multiplicity),
    .out_main_flag_o    (out_main_flag),
    .divide_fault_o     (divide_fault)
  );

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the calibration tables and gain register
  logic signed [31:0] corr_lin  [STRIP_DEPTH];
  logic signed [31:0] corr_quad [STRIP_DEPTH];
  logic               corr_ok   [STRIP_DEPTH] = '{default: 1'b0};
  logic signed [31:0] face_lin  [FACE_DEPTH];
  logic signed [31:0] face_quad [FACE_DEPTH];
  logic signed [31:0] gain_off  [STRIP_DEPTH];
  logic signed [31:0] gain_slope[STRIP_DEPTH];
  logic [30:0]        charge_gain_q = GAIN_RESET;

  cal_hit_t expected_hits[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_len = 0;
  int mismatches = 0;
  int hits_checked = 0;
  int items_sent = 0;
  int faults_seen = 0;

  function automatic longint sat32(input longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  // Update the shadow tables for a load, or compute the calibrated hit
  function automatic bit calibrate(input item_t it, output cal_hit_t r);
    int fidx, sidx;
    longint e, p, lin, quad, total, corr, diff, en, ch, pmm;
    r = '{default: '0};
    if (it.det >= NUM_DETECTORS) return 1'b0;
    fidx = it.det * NUM_FACES + it.face;
    sidx = fidx * NUM_STRIPS + it.strip;
    case (it.cmd)
      CMD_STRIP_CORR: begin
        corr_lin[sidx] = it.c1;
        corr_quad[sidx] = it.c2;
        corr_ok[sidx] = it.en;
        return 1'b0;
      end
      CMD_FACE_CORR: begin
        face_lin[fidx] = it.c1;
        face_quad[fidx] = it.c2;
        return 1'b0;
      end
      CMD_STRIP_GAIN: begin
        gain_off[sidx] = it.c1;
        gain_slope[sidx] = it.c2;
        return 1'b0;
      end
      default: ;
    endcase
    e = it.energy;
    p = it.pos;
    lin = corr_ok[sidx] ? corr_lin[sidx] : face_lin[fidx];
    quad = corr_ok[sidx] ? corr_quad[sidx] : face_quad[fidx];
    total = e * 64'sd268435456 - lin * p * 64'sd16384 - quad * p * p;
    corr = (total + 64'sd134217728) >>> 28;
    diff = corr - longint'(gain_off[sidx]);
    if (gain_slope[sidx] == 0) begin
      r.fault = 1'b1;
      en = (diff >= 0) ? SMAX : SMIN;
    end else begin
      en = sat32((diff * 64'sd65536) / longint'(gain_slope[sidx]));
    end
    ch = sat32((en * longint'({1'b0, charge_gain_q}) + 64'sd32768) >>> 16);
    pmm = sat32((p * 64'sd80278979 + 64'sd2097152) >>> 22);
    r.det = it.det;
    r.face = it.face;
    r.strip = it.strip;
    r.energy = en[31:0];
    r.charge = ch[31:0];
    r.pmm = pmm[31:0];
    r.tstamp = it.tstamp;
    r.mult = it.mult;
    r.mflag = it.mflag;
    return 1'b1;
  endfunction

  // Offer one item, wait for its transfer, then predict
  task automatic send_item(input item_t it);
    cal_hit_t r;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd <= it.cmd;
    detector <= it.det;
    face_sel <= it.face;
    strip_index <= it.strip;
    raw_energy <= it.energy;
    raw_position <= it.pos;
    hit_time <= it.tstamp;
    multiplicity <= it.mult;
    main_flag <= it.mflag;
    coef_first <= it.c1;
    coef_second <= it.c2;
    coef_enable <= it.en;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    if (calibrate(it, r)) expected_hits.insert(expected_hits.size(), r);
  endtask

  // Lower valid and let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [30:0] g);
    drain();
    cfg_data <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    charge_gain_q = g;
  endtask

  function automatic item_t hit_at(input int d, input int f, input int s);
    item_t it;
    it.cmd = CMD_HIT;
    it.det = 3'(d);
    it.face = 1'(f);
    it.strip = 6'(s);
    it.energy = $urandom();
    if ($urandom_range(1)) it.energy = $signed(32'($urandom_range(8000000))) - 4000000;
    it.pos = 16'($urandom());
    it.tstamp = $urandom();
    it.mult = 8'($urandom());
    it.mflag = 1'($urandom());
    it.c1 = $urandom();
    it.c2 = $urandom();
    it.en = 1'($urandom());
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed(32'($urandom_range(131072))) - 65536;
      2: return $signed(32'($urandom_range(4000)));
      default: return $signed(32'($urandom_range(2000000))) - 1000000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_slope();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom();
      2: return -$signed(32'($urandom_range(200000, 1)));
      default: return $signed(32'($urandom_range(200000, 1)));
    endcase
  endfunction

  function automatic item_t load_at(input cmd_e c, input int d, input int f, input int s);
    item_t it;
    it = hit_at(d, f, s);
    it.cmd = c;
    it.c1 = rand_coef();
    it.c2 = (c == CMD_STRIP_GAIN) ? rand_slope() : rand_coef();
    return it;
  endfunction

  // Mostly hits on loaded entries, some loads, a little out-of-range noise
  function automatic item_t rand_item();
    int k;
    item_t it;
    k = $urandom_range(99);
    if (k < 68)      it = hit_at($urandom_range(5), $urandom_range(1),
                                 $urandom_range(LOADED_STRIPS - 1));
    else if (k < 80) it = load_at(CMD_STRIP_CORR, $urandom_range(5), $urandom_range(1),
                                  $urandom_range(63));
    else if (k < 85) it = load_at(CMD_FACE_CORR, $urandom_range(5), $urandom_range(1),
                                  $urandom_range(63));
    else if (k < 93) it = load_at(CMD_STRIP_GAIN, $urandom_range(5), $urandom_range(1),
                                  $urandom_range(63));
    else begin
      it = load_at(cmd_e'($urandom_range(3)), $urandom_range(7, 6), $urandom_range(1),
                   $urandom_range(63));
      it.energy = $urandom();
    end
    return it;
  endfunction

  // Receiver: random stall, plus long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    int seen;
    int left;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      seen = 0;
      left = 0;
    end else begin
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        left = hold_len;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    cal_hit_t x;
    cal_hit_t a;
    if (rst_ni && out_valid && !out_stall) begin
      a = '{out_detector, out_face, out_strip, calibrated_energy, charge_estimate,
            position_mm, out_time, out_multiplicity, out_main_flag, divide_fault};
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] unexpected result: %p", $realtime, a);
      end else begin
        x = expected_hits.pop_front();
        hits_checked++;
        if (a.fault) faults_seen++;
        if (a !== x) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch\n  expected %p\n  actual   %p", $realtime, x, a);
        end
      end
    end
  end

  // Every face fallback and the gains of all strips that hits use get a value
  task automatic test_table_load();
    for (int f = 0; f < FACE_DEPTH; f++)
      send_item(load_at(CMD_FACE_CORR, f / NUM_FACES, f % NUM_FACES, $urandom_range(63)));
    for (int s = 0; s < FACE_DEPTH * LOADED_STRIPS; s++)
      send_item(load_at(CMD_STRIP_GAIN, s / (NUM_FACES * LOADED_STRIPS),
                        (s / LOADED_STRIPS) % NUM_FACES, s % LOADED_STRIPS));
  endtask

  // Field extremes, both correction sources, zero slope, out-of-range index
  task automatic test_directed();
    item_t it;
    it = load_at(CMD_STRIP_GAIN, 0, 0, 0);
    it.c1 = 0;
    it.c2 = 32'sd65536;
    send_item(it);
    it = hit_at(0, 0, 0);
    it.energy = 32'sh7fffffff; it.pos = 16'sh7fff; it.tstamp = '1; it.mult = '1;
    it.mflag = 1'b1;
    send_item(it);
    it.energy = 32'sh80000000; it.pos = 16'sh8000; it.tstamp = '0; it.mult = '0;
    it.mflag = 1'b0;
    send_item(it);
    it.energy = 0; it.pos = 0;
    send_item(it);
    // strip correction takes over from the face fallback
    it = load_at(CMD_STRIP_CORR, 0, 0, 0);
    it.c1 = 32'sh7fffffff; it.c2 = 32'sh80000000; it.en = 1'b1;
    send_item(it);
    it = hit_at(0, 0, 0); it.pos = 16'sh8000;
    send_item(it);
    it.pos = 16'sh7fff;
    send_item(it);
    // mark cleared again: back to face fallback
    it = load_at(CMD_STRIP_CORR, 0, 0, 0); it.en = 1'b0;
    send_item(it);
    send_item(hit_at(0, 0, 0));
    // face load ignores strip index
    send_item(load_at(CMD_FACE_CORR, 5, 1, 63));
    send_item(hit_at(5, 1, 5));
    // zero slope, both signs of the difference
    it = load_at(CMD_STRIP_GAIN, 5, 1, 63); it.c1 = 0; it.c2 = 0;
    send_item(it);
    it = hit_at(5, 1, 63); it.energy = 32'sh40000000; it.pos = 0;
    send_item(it);
    it.energy = 32'shc0000000;
    send_item(it);
    // tiny slope saturates through the divider
    it = load_at(CMD_STRIP_GAIN, 3, 0, 7); it.c1 = 32'sh80000000; it.c2 = 1;
    send_item(it);
    send_item(hit_at(3, 0, 7));
    it = load_at(CMD_STRIP_GAIN, 3, 0, 7); it.c1 = 32'sh7fffffff; it.c2 = -1;
    send_item(it);
    send_item(hit_at(3, 0, 7));
    // out-of-range detector: ignored loads and silent hits
    for (int c = 0; c < 4; c++) begin
      it = load_at(cmd_e'(c), 6 + (c % 2), c % 2, 63);
      send_item(it);
    end
    send_item(hit_at(0, 0, 0));
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_item(rand_item());
  endtask

  // Gain register at its extremes, reset value and a random value
  task automatic test_gain_sweep();
    logic [30:0] gains[4];
    gains = '{31'd1, 31'h7fffffff, GAIN_RESET, 31'($urandom_range(32'h7fffffff, 1))};
    foreach (gains[g]) begin
      write_gain(gains[g]);
      test_random(30, 20, 20);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_reqs++;
    for (int i = 0; i < 80; i++) send_item(hit_at($urandom_range(5), $urandom_range(1),
                                                   $urandom_range(LOADED_STRIPS - 1)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_table_load();
    test_directed();
    test_gain_sweep();
    test_random(30, 0, 0);
    test_random(30, 86, 0);
    test_random(30, 0, 86);
    test_random(30, 38, 38);
    test_backpressure();
    drain();
    $display("Sent %0d items, checked %0d calibrated hits (%0d divide faults),",
             items_sent, hits_checked, faults_seen);
    $display("over four gain settings, four idle mixes and a 300-cycle output hold-off.");
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_hits.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", expected_hits.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/shec_pkg.sv
src/shec_front.sv
src/shec_queue.sv
src/shec_div.sv
src/shec_back.sv
src/strip_hit_energy_calibrator.sv
sim/tb_top.sv
